// ----- rtl/core/cossim_pkg.sv -----
// Shared widths, types and constants of the cosine similarity block.
package cossim_pkg;

    // Field and datapath widths
    localparam int ELEM_W  = 16;               // element width
    localparam int MUL_W   = 2 * ELEM_W;       // element product
    localparam int ACC_W   = 43;               // accumulators, wrap modulo 2^ACC_W
    localparam int PROD_W  = 2 * ACC_W;        // product of the two sums of squares
    localparam int ROOT_W  = PROD_W / 2;       // floored root of that product
    localparam int REM_W   = ROOT_W + 1;       // root / divide remainder
    localparam int Q_W     = 16;               // score width, Q1.15
    localparam int ALU_W   = PROD_W;           // shared add/subtract unit
    localparam int CNT_W   = 6;                // step counter

    // Step counts of each phase
    localparam int MAC_STEPS  = 4;             // three products, one add trailing
    localparam int MUL_STEPS  = ACC_W;         // shift-add, one bit a cycle
    localparam int SQRT_STEPS = PROD_W / 2;    // two radicand bits a cycle
    localparam int DIV_STEPS  = Q_W;           // one quotient bit a cycle

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [MUL_W-1:0]  t_mul;
    typedef logic        [ACC_W-1:0]  t_acc;
    typedef logic        [ALU_W-1:0]  t_alu;
    typedef logic signed [Q_W-1:0]    t_score;

    // Saturation limits of the score
    localparam t_score SCORE_MAX  = 16'sh7FFF;
    localparam t_score SCORE_MIN  = 16'sh8000;
    localparam t_score SCORE_ZERO = 16'sh0000;

endpackage

// ----- rtl/core/cossim_if.sv -----
// Handshake channels of the cosine similarity block: element pairs in, scores out.
interface cossim_pair_if;
    logic                 valid;
    logic                 ready;
    cossim_pkg::t_elem    elem_a;
    cossim_pkg::t_elem    elem_b;
    logic                 last_pair;

    modport source (output valid, elem_a, elem_b, last_pair, input ready);
    modport sink   (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface cossim_score_if;
    logic                 valid;
    logic                 ready;
    cossim_pkg::t_score   score;
    logic                 degenerate;

    modport source (output valid, score, degenerate, input ready);
    modport sink   (input valid, score, degenerate, output ready);
endinterface

// ----- rtl/core/cosine_similarity.sv -----
// Top level: streaming cosine similarity with an iterative shared datapath.
//
//  channel  | dir | word                           | accepted when
//  i_pair   | in  | elem_a, elem_b, last_pair      | valid && ready
//  o_res    | out | score (Q1.15), degenerate      | valid && ready
//
//  An ordinary pair is accepted, then runs four multiply/accumulate steps.
//  A last pair then adds 43 shift-add steps for the product of the sums of
//  squares, 43 root steps and 16 divide steps, all through one adder.
//  A zero-norm last pair skips those phases. Reset is synchronous, active low.
//  A waiting result sits in the output register; the next vector streams in
//  meanwhile, and the next result waits, input closed, until the register is free.
module cosine_similarity (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cossim_pair_if.sink           i_pair,
    cossim_score_if.source        o_res
);

    localparam int ACC_W  = cossim_pkg::ACC_W;
    localparam int ALU_W  = cossim_pkg::ALU_W;
    localparam int PROD_W = cossim_pkg::PROD_W;
    localparam int ROOT_W = cossim_pkg::ROOT_W;
    localparam int REM_W  = cossim_pkg::REM_W;
    localparam int Q_W    = cossim_pkg::Q_W;
    localparam int CNT_W  = cossim_pkg::CNT_W;
    localparam int MUL_W  = cossim_pkg::MUL_W;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_NEG  = 4'd5;
    localparam logic [3:0] S_SAT  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt;
    cossim_pkg::t_elem   r_a, r_b;
    logic                r_last;
    cossim_pkg::t_acc    r_dot, r_ssa, r_ssb;
    logic [PROD_W-1:0]   r_p;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [Q_W-1:0]      r_q;
    logic                r_degen, r_sat;
    logic                r_out_valid;
    cossim_pkg::t_score  r_score;
    logic                r_out_degen;

    cossim_pkg::t_elem   mul_a, mul_b;
    cossim_pkg::t_mul    prod;
    cossim_pkg::t_alu    alu_a, alu_b, alu_res;
    logic                alu_sub, alu_carry;
    cossim_pkg::t_acc    acc_cur;
    logic [CNT_W-1:0]    bit_idx;
    logic [REM_W+1:0]    sqrt_cand;
    logic [REM_W:0]      div_cand;
    logic                div_bit;
    logic                last_step;
    logic                out_load;
    logic                neg;
    cossim_pkg::t_score  score_nx;

    cossim_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    cossim_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    assign i_pair.ready = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.score      = r_score;
    assign o_res.degenerate = r_out_degen;

    assign neg       = r_dot[ACC_W-1];
    assign bit_idx   = CNT_W'(ACC_W - 1) - r_cnt;
    assign sqrt_cand = {r_rem, r_p[PROD_W-1 -: 2]};
    assign div_bit   = (r_cnt == '0) ? r_p[0] : 1'b0;
    assign div_cand  = {r_rem, div_bit};
    assign out_load  = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    // accumulator picked by the multiply/accumulate step
    always_comb begin
        case (r_cnt[1:0])
            2'd1:    acc_cur = r_dot;
            2'd2:    acc_cur = r_ssa;
            default: acc_cur = r_ssb;
        endcase
    end

    // operand routing into the multiplier and the shared adder
    always_comb begin
        mul_a   = r_a;
        mul_b   = r_b;
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_MAC: begin
                case (r_cnt[1:0])
                    2'd0:    begin mul_a = r_a; mul_b = r_b; end
                    2'd1:    begin mul_a = r_a; mul_b = r_a; end
                    default: begin mul_a = r_b; mul_b = r_b; end
                endcase
                alu_a = ALU_W'(acc_cur);
                alu_b = {{(ALU_W-MUL_W){prod[MUL_W-1]}}, prod};
            end
            S_MUL: begin
                alu_a = {r_p[PROD_W-2:0], 1'b0};
                alu_b = r_ssb[bit_idx] ? ALU_W'(r_ssa) : '0;
            end
            S_SQRT: begin
                alu_a   = ALU_W'(sqrt_cand);
                alu_b   = ALU_W'({r_root, 2'b01});
                alu_sub = 1'b1;
            end
            S_NEG: begin
                alu_b   = ALU_W'(r_dot);
                alu_sub = neg;
            end
            S_SAT: begin
                alu_a   = r_p;
                alu_b   = ALU_W'({r_root, 1'b0});
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = ALU_W'(div_cand);
                alu_b   = ALU_W'(r_root);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // end of the current iterative phase
    always_comb begin
        case (r_state)
            S_MAC:   last_step = (r_cnt == CNT_W'(cossim_pkg::MAC_STEPS - 1));
            S_MUL:   last_step = (r_cnt == CNT_W'(cossim_pkg::MUL_STEPS - 1));
            S_SQRT:  last_step = (r_cnt == CNT_W'(cossim_pkg::SQRT_STEPS - 1));
            S_DIV:   last_step = (r_cnt == CNT_W'(cossim_pkg::DIV_STEPS - 1));
            default: last_step = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_pair.valid) n_state = S_MAC;
            S_MAC:  if (last_step) n_state = r_last ? S_CHK : S_IDLE;
            S_CHK:  n_state = ((r_ssa == '0) || (r_ssb == '0)) ? S_FIN : S_MUL;
            S_MUL:  if (last_step) n_state = S_SQRT;
            S_SQRT: if (last_step) n_state = S_NEG;
            S_NEG:  n_state = S_SAT;
            S_SAT:  n_state = alu_carry ? S_FIN : S_DIV;
            S_DIV:  if (last_step) n_state = S_FIN;
            S_FIN:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // score from quotient, sign and the special cases
    always_comb begin
        if (r_degen) begin
            score_nx = cossim_pkg::SCORE_ZERO;
        end else if (r_sat || r_q[Q_W-1]) begin
            score_nx = neg ? cossim_pkg::SCORE_MIN : cossim_pkg::SCORE_MAX;
        end else if (neg) begin
            score_nx = cossim_pkg::t_score'(-r_q);
        end else begin
            score_nx = cossim_pkg::t_score'(r_q);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_dot       <= '0;
            r_ssa       <= '0;
            r_ssb       <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state || last_step) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end

            // accumulate one product per step, after the multiplier register
            if (r_state == S_MAC) begin
                case (r_cnt[1:0])
                    2'd1:    r_dot <= alu_res[ACC_W-1:0];
                    2'd2:    r_ssa <= alu_res[ACC_W-1:0];
                    2'd3:    r_ssb <= alu_res[ACC_W-1:0];
                    default: r_dot <= r_dot;
                endcase
            end

            // hand the result over and clear the vector state
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_dot       <= '0;
                r_ssa       <= '0;
                r_ssb       <= '0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_pair.valid && i_pair.ready) begin
            r_a    <= i_pair.elem_a;
            r_b    <= i_pair.elem_b;
            r_last <= i_pair.last_pair;
        end

        case (r_state)
            S_CHK: begin
                r_degen <= (r_ssa == '0) || (r_ssb == '0);
                r_sat   <= 1'b0;
                r_p     <= '0;
            end
            S_MUL: begin
                r_p <= alu_res;
                if (last_step) begin
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            S_SQRT: begin
                r_p <= {r_p[PROD_W-3:0], 2'b00};
                if (alu_carry) begin
                    r_rem  <= alu_res[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= sqrt_cand[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            S_NEG: begin
                r_p <= PROD_W'(alu_res[ACC_W-1:0]);
            end
            S_SAT: begin
                r_sat <= alu_carry;
                r_rem <= REM_W'(r_p[ACC_W-1:1]);
                r_q   <= '0;
            end
            S_DIV: begin
                if (alu_carry) begin
                    r_rem <= alu_res[REM_W-1:0];
                end else begin
                    r_rem <= div_cand[REM_W-1:0];
                end
                r_q <= {r_q[Q_W-2:0], alu_carry};
            end
            default: begin
                r_p <= r_p;
            end
        endcase

        if (out_load) begin
            r_score     <= score_nx;
            r_out_degen <= r_degen;
        end
    end

`ifndef SYNTHESIS
    // an accepted word keeps the input closed for the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pair.valid && i_pair.ready) |=> !i_pair.ready)
        else $error("input ready right after an accepted word");

    // root remainder never exceeds twice the partial root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_rem <= {r_root, 1'b0}))
        else $error("root remainder out of range");

    // divide remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < REM_W'(r_root)))
        else $error("divide remainder not below root");

    // accumulators are clear once a result is handed over
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> ((r_dot == '0) && (r_ssa == '0) && (r_ssb == '0) && r_out_valid))
        else $error("accumulators not cleared after result");
`endif

endmodule

// ----- rtl/core/cossim_mul.sv -----
// Registered signed element multiplier, shared by the three products of a pair.
module cossim_mul (
    input  logic              i_clk,
    input  cossim_pkg::t_elem i_a,
    input  cossim_pkg::t_elem i_b,
    output cossim_pkg::t_mul  o_p
);

    cossim_pkg::t_mul r_p;

    // one product a cycle, registered before the accumulate
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/cossim_alu.sv -----
// Shared wide add/subtract unit; carry out on subtract means a >= b.
module cossim_alu (
    input  cossim_pkg::t_alu i_a,
    input  cossim_pkg::t_alu i_b,
    input  logic             i_sub,
    output cossim_pkg::t_alu o_res,
    output logic             o_carry
);

    localparam int W = cossim_pkg::ALU_W;

    logic [W:0] sum;
    logic [W-1:0] b_op;

    // subtract as add of the inverted operand plus one
    assign b_op = i_sub ? ~i_b : i_b;
    assign sum  = {1'b0, i_a} + {1'b0, b_op} + {{W{1'b0}}, i_sub};

    assign o_res   = sum[W-1:0];
    assign o_carry = sum[W];

endmodule
